// ===== sv/msfe_pkg.sv =====
// Shared types, codes and constants of the multi-sensor fusion engine.
package msfe_pkg;

    localparam int VAL_W      = 32;  // Q16.16 reading and fused value
    localparam int WGT_W      = 16;  // Q8.8 weight
    localparam int TIME_W     = 32;  // millisecond stamps and timeouts
    localparam int NOISE_W    = 32;  // Q16.16 Kalman noise terms
    localparam int CONF_W     = 17;  // Q1.16 confidence, up to 1.0
    localparam int CNT_W      = 4;   // source counts, up to 15
    localparam int MODE_W     = 3;
    localparam int OP_W       = 2;
    localparam int SIDX_W     = 3;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // shared multiplier: signed 18 x 34 bits
    localparam int MUL_AW = 18;
    localparam int MUL_BW = 34;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // shared divider: unsigned 56 / 34 bits, one quotient bit per cycle
    localparam int DIV_NW = 56;
    localparam int DIV_DW = 34;

    localparam int ACC_W  = 54;  // weighted sum
    localparam int WSUM_W = 20;  // sum of weights
    localparam int PRED_W = NOISE_W + 1;

    localparam logic [WGT_W-1:0]   WEIGHT_ONE  = 16'd256;
    localparam logic [TIME_W-1:0]  TIMEOUT_RST = 32'd5000;
    localparam logic [CONF_W-1:0]  ONE_Q16     = 17'd65536;
    localparam logic [NOISE_W-1:0] PNOISE_RST  = 32'd655;
    localparam logic [NOISE_W-1:0] MNOISE_RST  = 32'd6554;
    localparam logic [CNT_W-1:0]   IN_USE_RST  = 4'd1;

    typedef enum logic [OP_W-1:0] {
        OP_STORE  = 2'd0,
        OP_CONFIG = 2'd1,
        OP_FUSE   = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_RANGE   = 2'd1,
        STAT_NOFRESH = 2'd2
    } status_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_AVG   = 3'd0,
        MODE_KAL   = 3'd1,
        MODE_VOTE  = 3'd2,
        MODE_UNAN  = 3'd3,
        MODE_MAX   = 3'd4,
        MODE_MIN   = 3'd5
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_IN_USE = 2'd1,
        CFG_PNOISE = 2'd2,
        CFG_MNOISE = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// ===== sv/msfe_ifs.sv =====
// Handshake channel interfaces of the fusion engine: items, results, configuration.
interface msfe_item_if import msfe_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic [SIDX_W-1:0]        source_index;
    logic signed [VAL_W-1:0]  reading;
    logic [TIME_W-1:0]        now_ms;
    logic [WGT_W-1:0]         source_weight_in;
    logic [TIME_W-1:0]        stale_limit_ms;

    modport source (output valid, opcode, source_index, reading, now_ms,
                    source_weight_in, stale_limit_ms, input ready);
    modport sink   (input valid, opcode, source_index, reading, now_ms,
                    source_weight_in, stale_limit_ms, output ready);
endinterface

interface msfe_result_if import msfe_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [VAL_W-1:0]  fused_out;
    logic [CONF_W-1:0]        confidence_out;
    logic [CNT_W-1:0]         fresh_count;

    modport source (output valid, status, fused_out, confidence_out, fresh_count,
                    input ready);
    modport sink   (input valid, status, fused_out, confidence_out, fresh_count,
                    output ready);
endinterface

interface msfe_cfg_if import msfe_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_W-1:0]     index;
    logic [CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/msfe_mul.sv =====
// Shared signed multiplier with a registered product.
module msfe_mul
    import msfe_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_AW-1:0]  a,
    input  logic signed [MUL_BW-1:0]  b,
    output logic signed [MUL_PW-1:0]  p
);

    logic signed [MUL_PW-1:0] prod;
    logic signed [MUL_PW-1:0] p_reg;

    // form the full-width product
    assign prod = MUL_PW'(a) * MUL_PW'(b);

    // register the product
    always_ff @(posedge clk)
    begin
        p_reg <= prod;
    end

    assign p = p_reg;

endmodule

// ===== sv/msfe_div.sv =====
// Shared unsigned restoring divider, one quotient bit per cycle.
module msfe_div
    import msfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_NW-1:0]  dividend,
    input  logic [DIV_DW-1:0]  divisor,
    output logic [DIV_NW-1:0]  quotient,
    output div_sts_t           sts
);

    localparam int STEP_W = $clog2(DIV_NW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] dvs_reg;

    logic [DIV_DW:0]   trial;
    logic              fits;
    logic [DIV_DW-1:0] rem_next;

    // shift in the next dividend bit and try a subtract
    assign trial    = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_next = fits ? DIV_DW'(trial - {1'b0, dvs_reg}) : DIV_DW'(trial);

    // advance one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIV_NW);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                quo_reg  <= {quo_reg[DIV_NW-2:0], fits};
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// ===== sv/multi_sensor_fusion_engine_top.sv =====
// Fusion engine top level: source store, operation sequencer, shared multiplier and divider.
//
// One item is taken at a time; ready stays low until its result is in the output register.
// A store or configure item walks the n sources of the group (sources in use, capped at
// SOURCES) to count the fresh ones. A fuse walks the group once to age and count sources,
// then runs the mode: weighted average by multiply, accumulate and divide, Kalman with one
// gain and update per fresh source, max and min from a scan of the group, and votes from that
// scan plus a rank search over the candidates. Every fuse with a fresh source ends with a
// confidence division on the 56-step shared divider.
// The result register lets the next item be taken while a result waits to be read.
module multi_sensor_fusion_engine_top
    import msfe_pkg::*;
#(
    parameter int SOURCES = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    msfe_item_if.sink     item,
    msfe_result_if.source result,
    msfe_cfg_if.sink      cfg
);

    localparam int IDX_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int PTR_W  = ($clog2(SOURCES + 1) > CNT_W) ? $clog2(SOURCES + 1) : CNT_W;
    localparam logic [PTR_W-1:0] SRC_MAX = PTR_W'(SOURCES);

    typedef enum logic [4:0] {
        S_IDLE,
        S_COUNT,
        S_AVG_MUL,
        S_AVG_ACC,
        S_AVG_DIV,
        S_KAL_PRED,
        S_KAL_DIV,
        S_KAL_MUL1,
        S_KAL_MUL2,
        S_KAL_UPD,
        S_EXT,
        S_VLOAD,
        S_VCMP,
        S_CONF,
        S_CONF_WAIT,
        S_DONE
    } state_t;

    // configuration
    logic [MODE_W-1:0]       mode_reg;
    logic [CNT_W-1:0]        in_use_reg;
    logic [NOISE_W-1:0]      pnoise_reg;
    logic [NOISE_W-1:0]      mnoise_reg;

    // source store
    logic signed [VAL_W-1:0] val_reg    [SOURCES];
    logic [WGT_W-1:0]        weight_reg [SOURCES];
    logic [TIME_W-1:0]       tmo_reg    [SOURCES];
    logic [TIME_W-1:0]       stamp_reg  [SOURCES];
    logic [SOURCES-1:0]      upd_reg;
    logic [SOURCES-1:0]      stale_reg;

    // sequencer
    state_t                  state_reg;
    logic [PTR_W-1:0]        ptr_reg;
    logic [PTR_W-1:0]        j_reg;
    logic [OP_W-1:0]         op_reg;
    logic [TIME_W-1:0]       now_reg;
    status_t                 status_reg;
    logic [CNT_W-1:0]        fresh_reg;
    logic [CNT_W-1:0]        lt_reg;
    logic [CNT_W-1:0]        le_reg;
    logic signed [VAL_W-1:0] cand_reg;
    logic signed [VAL_W-1:0] max_reg;
    logic signed [VAL_W-1:0] min_reg;
    logic                    have_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [WSUM_W-1:0]       wsum_reg;
    logic [PRED_W-1:0]       pred_reg;
    logic [CONF_W-1:0]       k_reg;

    // fusion state
    logic signed [VAL_W-1:0] est_reg;
    logic [NOISE_W-1:0]      cov_reg;
    logic signed [VAL_W-1:0] fused_reg;
    logic [CONF_W-1:0]       conf_reg;

    // result register
    logic                    ovalid_reg;
    logic [STAT_W-1:0]       ostat_reg;
    logic signed [VAL_W-1:0] ofused_reg;
    logic [CONF_W-1:0]       oconf_reg;
    logic [CNT_W-1:0]        ofresh_reg;

    // shared units
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;
    logic                     div_start;
    logic [DIV_NW-1:0]        div_num;
    logic [DIV_DW-1:0]        div_den;
    logic [DIV_NW-1:0]        div_quo;
    div_sts_t                 div_sts;

    // combinational helpers
    logic [PTR_W-1:0]         n_w;
    logic [IDX_W-1:0]         rd_idx;
    logic [IDX_W-1:0]         wr_idx;
    logic                     at_end;
    logic signed [VAL_W-1:0]  cur_val;
    logic                     cur_stale;
    logic [TIME_W-1:0]        age;
    logic                     ages_out;
    logic                     idx_ok;
    logic                     accept;
    logic                     src_fresh;
    logic [PRED_W-1:0]        pred_w;
    logic [DIV_DW-1:0]        den_w;
    logic signed [ACC_W-1:0]  acc_mag;
    logic [VAL_W-1:0]         q_low;
    logic signed [MUL_PW-1:0] est_sum;
    logic [MUL_PW-17:0]       cov_shift;
    logic signed [VAL_W:0]    spread;
    logic signed [VAL_W:0]    mid2;
    logic [VAL_W:0]           mid2_abs;
    logic [VAL_W+5:0]         spread20;
    logic                     unan_fail;
    logic [CNT_W-1:0]         lt_next;
    logic [CNT_W-1:0]         le_next;
    logic [CNT_W-1:0]         median_pos;

    msfe_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    msfe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quo),
        .sts      (div_sts)
    );

    // group size and source read port
    assign n_w       = (PTR_W'(in_use_reg) > SRC_MAX) ? SRC_MAX : PTR_W'(in_use_reg);
    assign rd_idx    = IDX_W'((state_reg == S_VLOAD) ? j_reg : ptr_reg);
    assign wr_idx    = IDX_W'(item.source_index);
    assign at_end    = (ptr_reg == n_w);
    assign cur_val   = val_reg[rd_idx];
    assign cur_stale = stale_reg[rd_idx];
    assign age       = now_reg - stamp_reg[rd_idx];
    assign ages_out  = upd_reg[rd_idx] && (tmo_reg[rd_idx] != '0) && (age > tmo_reg[rd_idx]);
    assign idx_ok    = PTR_W'(item.source_index) < n_w;
    assign accept    = item.valid && item.ready;
    assign src_fresh = !cur_stale;

    // Kalman prediction and gain denominator
    assign pred_w = PRED_W'(cov_reg) + PRED_W'(pnoise_reg);
    assign den_w  = DIV_DW'(pred_w) + DIV_DW'(mnoise_reg);

    // weighted average magnitude and signed quotient
    assign acc_mag = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign q_low   = div_quo[VAL_W-1:0];

    // Kalman estimate and covariance updates from the product
    assign est_sum   = MUL_PW'(est_reg) + (mul_p >>> 16);
    assign cov_shift = mul_p[MUL_PW-1:16];

    // unanimous spread test: 20 * (max - min) > |max + min|
    assign spread    = (VAL_W+1)'(max_reg) - (VAL_W+1)'(min_reg);
    assign mid2      = (VAL_W+1)'(max_reg) + (VAL_W+1)'(min_reg);
    assign mid2_abs  = mid2[VAL_W] ? (VAL_W+1)'(-mid2) : (VAL_W+1)'(mid2);
    assign spread20  = (VAL_W+6)'({spread, 4'b0}) + (VAL_W+6)'({spread, 2'b0});
    assign unan_fail = spread20 > (VAL_W+6)'(mid2_abs);

    // rank counts for the vote
    assign lt_next    = lt_reg + CNT_W'(src_fresh && (cur_val < cand_reg));
    assign le_next    = le_reg + CNT_W'(src_fresh && (cur_val <= cand_reg));
    assign median_pos = fresh_reg >> 1;

    // drive the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_AVG_MUL:
            begin
                mul_a = MUL_AW'({1'b0, weight_reg[rd_idx]});
                mul_b = MUL_BW'(cur_val);
            end
            S_KAL_MUL1:
            begin
                mul_a = MUL_AW'({1'b0, k_reg});
                mul_b = MUL_BW'(cur_val) - MUL_BW'(est_reg);
            end
            S_KAL_MUL2:
            begin
                mul_a = MUL_AW'({1'b0, ONE_Q16 - k_reg});
                mul_b = MUL_BW'({1'b0, pred_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // drive the shared divider
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            S_AVG_MUL:
            begin
                div_start = at_end;
                div_num   = DIV_NW'(acc_mag);
                div_den   = DIV_DW'(wsum_reg);
            end
            S_KAL_PRED:
            begin
                div_start = !at_end && src_fresh && (den_w != '0);
                div_num   = DIV_NW'({pred_w, 16'b0});
                div_den   = den_w;
            end
            S_CONF:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'({fresh_reg, 16'b0});
                div_den   = DIV_DW'(n_w);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // sequencer, source store, fusion state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_AVG;
            in_use_reg <= IN_USE_RST;
            pnoise_reg <= PNOISE_RST;
            mnoise_reg <= MNOISE_RST;
            for (int i = 0; i < SOURCES; i++)
            begin
                val_reg[i]    <= '0;
                weight_reg[i] <= WEIGHT_ONE;
                tmo_reg[i]    <= TIMEOUT_RST;
                stamp_reg[i]  <= '0;
            end
            upd_reg    <= '0;
            stale_reg  <= '0;
            state_reg  <= S_IDLE;
            ptr_reg    <= '0;
            j_reg      <= '0;
            op_reg     <= OP_NOP;
            now_reg    <= '0;
            status_reg <= STAT_OK;
            fresh_reg  <= '0;
            lt_reg     <= '0;
            le_reg     <= '0;
            cand_reg   <= '0;
            max_reg    <= '0;
            min_reg    <= '0;
            have_reg   <= 1'b0;
            acc_reg    <= '0;
            wsum_reg   <= '0;
            pred_reg   <= '0;
            k_reg      <= '0;
            est_reg    <= '0;
            cov_reg    <= NOISE_W'(ONE_Q16);
            fused_reg  <= '0;
            conf_reg   <= '0;
            ovalid_reg <= 1'b0;
            ostat_reg  <= STAT_OK;
            ofused_reg <= '0;
            oconf_reg  <= '0;
            ofresh_reg <= '0;
        end
        else
        begin
            // take configuration writes
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_MODE:   mode_reg   <= cfg.data[MODE_W-1:0];
                    CFG_IN_USE: in_use_reg <= cfg.data[CNT_W-1:0];
                    CFG_PNOISE: pnoise_reg <= cfg.data[NOISE_W-1:0];
                    CFG_MNOISE: mnoise_reg <= cfg.data[NOISE_W-1:0];
                    default:    mode_reg   <= mode_reg;
                endcase
            end

            // drop the result once taken; a waiting result reloads it instead
            if (result.ready && state_reg != S_DONE)
            begin
                ovalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= item.opcode;
                        now_reg    <= item.now_ms;
                        status_reg <= STAT_OK;
                        ptr_reg    <= '0;
                        fresh_reg  <= '0;
                        state_reg  <= S_COUNT;
                        if ((item.opcode == OP_STORE || item.opcode == OP_CONFIG) && !idx_ok)
                        begin
                            status_reg <= STAT_RANGE;
                        end
                        else if (item.opcode == OP_STORE)
                        begin
                            val_reg[wr_idx]   <= item.reading;
                            stamp_reg[wr_idx] <= item.now_ms;
                            upd_reg[wr_idx]   <= 1'b1;
                            stale_reg[wr_idx] <= 1'b0;
                        end
                        else if (item.opcode == OP_CONFIG)
                        begin
                            weight_reg[wr_idx] <= (item.source_weight_in == '0) ?
                                                  WEIGHT_ONE : item.source_weight_in;
                            tmo_reg[wr_idx]    <= item.stale_limit_ms;
                        end
                    end
                end

                // age sources on a fuse and count the fresh ones
                S_COUNT:
                begin
                    if (at_end)
                    begin
                        ptr_reg  <= '0;
                        acc_reg  <= '0;
                        wsum_reg <= '0;
                        have_reg <= 1'b0;
                        if (op_reg != OP_FUSE)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (fresh_reg == '0)
                        begin
                            conf_reg   <= '0;
                            status_reg <= STAT_NOFRESH;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            unique case (mode_reg)
                                MODE_AVG:  state_reg <= S_AVG_MUL;
                                MODE_KAL:  state_reg <= S_KAL_PRED;
                                MODE_VOTE,
                                MODE_UNAN,
                                MODE_MAX,
                                MODE_MIN:  state_reg <= S_EXT;
                                default:   state_reg <= S_CONF;
                            endcase
                        end
                    end
                    else
                    begin
                        if (op_reg == OP_FUSE && ages_out)
                        begin
                            stale_reg[rd_idx] <= 1'b1;
                        end
                        if (!(cur_stale || (op_reg == OP_FUSE && ages_out)))
                        begin
                            fresh_reg <= fresh_reg + 1'b1;
                        end
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end

                // weighted average: multiply, accumulate, divide
                S_AVG_MUL:
                begin
                    if (at_end)
                    begin
                        state_reg <= S_AVG_DIV;
                    end
                    else if (cur_stale)
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_AVG_ACC;
                    end
                end

                S_AVG_ACC:
                begin
                    acc_reg   <= acc_reg + ACC_W'(mul_p);
                    wsum_reg  <= wsum_reg + WSUM_W'(weight_reg[rd_idx]);
                    ptr_reg   <= ptr_reg + 1'b1;
                    state_reg <= S_AVG_MUL;
                end

                S_AVG_DIV:
                begin
                    if (div_sts.done)
                    begin
                        fused_reg <= acc_reg[ACC_W-1] ? (~q_low + 1'b1) : q_low;
                        state_reg <= S_CONF;
                    end
                end

                // Kalman: one update per fresh source in index order
                S_KAL_PRED:
                begin
                    if (at_end)
                    begin
                        fused_reg <= est_reg;
                        state_reg <= S_CONF;
                    end
                    else if (cur_stale)
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    else
                    begin
                        pred_reg <= pred_w;
                        if (den_w == '0)
                        begin
                            k_reg     <= ONE_Q16;
                            state_reg <= S_KAL_MUL1;
                        end
                        else
                        begin
                            state_reg <= S_KAL_DIV;
                        end
                    end
                end

                S_KAL_DIV:
                begin
                    if (div_sts.done)
                    begin
                        k_reg     <= div_quo[CONF_W-1:0];
                        state_reg <= S_KAL_MUL1;
                    end
                end

                S_KAL_MUL1:
                begin
                    state_reg <= S_KAL_MUL2;
                end

                S_KAL_MUL2:
                begin
                    est_reg   <= est_sum[VAL_W-1:0];
                    state_reg <= S_KAL_UPD;
                end

                S_KAL_UPD:
                begin
                    cov_reg   <= (|cov_shift[MUL_PW-17:NOISE_W]) ? '1 :
                                 cov_shift[NOISE_W-1:0];
                    ptr_reg   <= ptr_reg + 1'b1;
                    state_reg <= S_KAL_PRED;
                end

                // find max and min of the fresh readings
                S_EXT:
                begin
                    if (at_end)
                    begin
                        j_reg <= '0;
                        priority case (mode_reg)
                            MODE_MAX:
                            begin
                                fused_reg <= max_reg;
                                state_reg <= S_CONF;
                            end
                            MODE_MIN:
                            begin
                                fused_reg <= min_reg;
                                state_reg <= S_CONF;
                            end
                            default:
                            begin
                                state_reg <= S_VLOAD;
                            end
                        endcase
                    end
                    else
                    begin
                        if (src_fresh)
                        begin
                            if (!have_reg || cur_val > max_reg)
                            begin
                                max_reg <= cur_val;
                            end
                            if (!have_reg || cur_val < min_reg)
                            begin
                                min_reg <= cur_val;
                            end
                            have_reg <= 1'b1;
                        end
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end

                // vote: take the next fresh candidate
                S_VLOAD:
                begin
                    if (j_reg == n_w)
                    begin
                        state_reg <= S_CONF;
                    end
                    else if (cur_stale)
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        cand_reg  <= cur_val;
                        lt_reg    <= '0;
                        le_reg    <= '0;
                        ptr_reg   <= '0;
                        state_reg <= S_VCMP;
                    end
                end

                // vote: rank the candidate against every fresh reading
                S_VCMP:
                begin
                    if (at_end)
                    begin
                        if (lt_reg <= median_pos && le_reg > median_pos)
                        begin
                            fused_reg <= (mode_reg == MODE_UNAN && unan_fail) ? '0 : cand_reg;
                            state_reg <= S_CONF;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_VLOAD;
                        end
                    end
                    else
                    begin
                        lt_reg  <= lt_next;
                        le_reg  <= le_next;
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end

                // confidence = fresh / n
                S_CONF:
                begin
                    state_reg <= S_CONF_WAIT;
                end

                S_CONF_WAIT:
                begin
                    if (div_sts.done)
                    begin
                        conf_reg  <= div_quo[CONF_W-1:0];
                        state_reg <= S_DONE;
                    end
                end

                // hold until the result register is free
                S_DONE:
                begin
                    if (!ovalid_reg || result.ready)
                    begin
                        ovalid_reg <= 1'b1;
                        ostat_reg  <= status_reg;
                        ofused_reg <= fused_reg;
                        oconf_reg  <= conf_reg;
                        ofresh_reg <= (status_reg == STAT_NOFRESH) ? '0 : fresh_reg;
                        state_reg  <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // channel outputs
    assign item.ready            = (state_reg == S_IDLE);
    assign cfg.ready             = 1'b1;
    assign result.valid          = ovalid_reg;
    assign result.status         = ostat_reg;
    assign result.fused_out      = ofused_reg;
    assign result.confidence_out = oconf_reg;
    assign result.fresh_count    = ofresh_reg;

    // the divider is never restarted while it is still working
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_sts.busy)
        else $error("divider started while busy");

    // an accepted request keeps the block busy on the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !item.ready)
        else $error("request accepted while previous one still in flight");

    // a fuse with no fresh source reports zero confidence
    a_nofresh_conf: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == STAT_NOFRESH) |-> (result.confidence_out == '0))
        else $error("no fresh sources but nonzero confidence");

endmodule
